/* rtl/pcm_sample_format_converter_top_assert.svh */
// Assertion macros for the PCM sample format converter.
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define PSFC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcm converter check failed");

// Next-cycle implication, masked while reset is high.
`define PSFC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcm converter check failed");

`endif

/* rtl/pcm_sfc_pkg.sv */
// Package: format codes, register indexes and sample conversion functions.
`timescale 1ns / 1ps
package pcm_sfc_pkg;

   localparam logic [1:0] FMT_S16   = 2'd0;
   localparam logic [1:0] FMT_S32   = 2'd1;
   localparam logic [1:0] FMT_FLOAT = 2'd2;

   localparam logic REG_SOURCE = 1'b0;
   localparam logic REG_TARGET = 1'b1;

   localparam logic [31:0] S16_POS_MAX = 32'h0000_7FFF;
   localparam logic [31:0] S16_NEG_MAX = 32'hFFFF_8001;
   localparam logic [31:0] S32_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_NEG_MAX = 32'h8000_0000;
   localparam logic [30:0] FLOAT_ONE   = 31'h3F80_0000;
   localparam logic [30:0] FLOAT_OVER  = 31'h3F80_0100; // 32768/32767 rounded

   // Count leading zeros in five halving steps.
   function automatic logic [4:0] lead_zeros(input logic [31:0] x);
      logic [4:0]  lz;
      logic [31:0] v;
      lz = 5'd0;
      v  = x;
      if (v[31:16] == 16'd0) begin
         lz[4] = 1'b1;
         v     = v << 16;
      end
      if (v[31:24] == 8'd0) begin
         lz[3] = 1'b1;
         v     = v << 8;
      end
      if (v[31:28] == 4'd0) begin
         lz[2] = 1'b1;
         v     = v << 4;
      end
      if (v[31:30] == 2'd0) begin
         lz[1] = 1'b1;
         v     = v << 2;
      end
      if (v[31] == 1'b0) begin
         lz[0] = 1'b1;
      end
      return lz;
   endfunction

   // Signed 16 divided by 32767, round to nearest even.
   // m/32767 for m below 32767 is the 15-bit pattern of m repeating forever,
   // so the sticky bit is always set and rounding follows the guard bit.
   function automatic logic [31:0] s16_to_float(input logic [15:0] w);
      logic        sgn;
      logic [15:0] m;
      logic [4:0]  lz;
      logic [59:0] f;
      logic [31:0] res;
      sgn = w[15];
      m   = sgn ? 16'(~w + 16'd1) : w;
      lz  = lead_zeros({m[14:0], 17'd0});
      f   = {4{m[14:0]}} << lz;
      if (m == 16'd0) begin
         res = 32'd0;
      end else if (m == 16'h7FFF) begin
         res = {sgn, FLOAT_ONE};
      end else if (m == 16'h8000) begin
         res = {sgn, FLOAT_OVER};
      end else begin
         res = {sgn, 8'(8'd126 - {3'd0, lz}), f[58:36]} + {31'd0, f[35]};
      end
      return res;
   endfunction

   // Signed 32 to float (round to nearest even), then scale by 2^-31.
   function automatic logic [31:0] s32_to_float(input logic [31:0] w);
      logic        sgn;
      logic [31:0] m;
      logic [4:0]  lz;
      logic [31:0] n;
      logic        rnd;
      logic [31:0] res;
      sgn = w[31];
      m   = sgn ? (~w + 32'd1) : w;
      lz  = lead_zeros(m);
      n   = m << lz;
      rnd = n[7] & ((|n[6:0]) | n[8]);
      if (m == 32'd0) begin
         res = 32'd0;
      end else begin
         res = {sgn, 8'(8'd127 - {3'd0, lz}), n[30:8]} + {31'd0, rnd};
      end
      return res;
   endfunction

   // Clamp a float to [-1,1], scale, truncate. Bit 32 is the saturation flag.
   function automatic logic [32:0] float_to_int(input logic [31:0] f,
                                                input logic to_s16);
      logic        sgn;
      logic [7:0]  e;
      logic [23:0] mant;
      logic [38:0] p;
      logic [24:0] r;
      logic [7:0]  k;
      logic [30:0] mag32;
      logic [24:0] mag16;
      logic [32:0] res;
      sgn   = f[31];
      e     = f[30:23];
      mant  = {(e != 8'd0), f[22:0]};
      p     = 39'(mant) * 39'd32767;
      if (p[38]) begin
         r = 25'(p[38:15]) + 25'(p[14] & ((|p[13:0]) | p[15]));
         k = 8'd135 - e;
      end else begin
         r = 25'(p[37:14]) + 25'(p[13] & ((|p[12:0]) | p[14]));
         k = 8'd136 - e;
      end
      mag16 = r >> k;
      mag32 = {mant, 7'd0} >> (8'd126 - e);
      if (e == 8'hFF && f[22:0] != 23'd0) begin
         res = {1'b1, 32'd0};
      end else if (e >= 8'd127) begin
         if (to_s16) begin
            res = {1'b0, sgn ? S16_NEG_MAX : S16_POS_MAX};
         end else if (sgn) begin
            res = {1'b0, S32_NEG_MAX};
         end else begin
            res = {1'b1, S32_POS_MAX};
         end
      end else if (to_s16) begin
         res = {1'b0, sgn ? (32'd0 - {7'd0, mag16}) : {7'd0, mag16}};
      end else begin
         res = {1'b0, sgn ? (32'd0 - {1'b0, mag32}) : {1'b0, mag32}};
      end
      return res;
   endfunction

endpackage

/* rtl/pcm_sample_format_converter_top.sv */
// Top level: PCM sample format converter with input and result registers.
//
//   Channel | Direction | Ports                       | Contents
//   req     | in        | req_tvalid/tready/tdata     | tdata[31:0] sample_word
//   rsp     | out       | rsp_tvalid/tready/tdata/user| tdata converted_word, tuser saturated
//   csr     | in        | csr_we/addr/wdata           | 0 source_format, 1 target_format
//
// One sample per clock unless the result stalls; input register, then result register.
// The conversion runs as one combinational pass between the two registers.
// A stalled result holds both stages; the input side still takes a transfer
// while the input register is empty or moving. Reset is synchronous and
// sets both formats to float.
`timescale 1ns / 1ps
module pcm_sample_format_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] converted_word
   output logic        rsp_tuser,   // [0] saturated
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [1:0]  csr_wdata
);

   logic [1:0]  source_format_ff, source_format_in;
   logic [1:0]  target_format_ff, target_format_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff, s1_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_sat_ff, rsp_sat_in;
   logic        advance;
   logic [31:0] float_bits;
   logic [32:0] int_res;
   logic [31:0] conv_word;
   logic        conv_sat;

   // Configuration writes
   always_comb begin
      source_format_in = source_format_ff;
      target_format_in = target_format_ff;
      if (csr_we) begin
         case (csr_addr)
            pcm_sfc_pkg::REG_SOURCE: source_format_in = csr_wdata;
            pcm_sfc_pkg::REG_TARGET: target_format_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: advance when the result register is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   // Convert the held sample
   always_comb begin
      case (source_format_ff)
         pcm_sfc_pkg::FMT_S16: float_bits = pcm_sfc_pkg::s16_to_float(s1_word_ff[15:0]);
         pcm_sfc_pkg::FMT_S32: float_bits = pcm_sfc_pkg::s32_to_float(s1_word_ff);
         default:              float_bits = s1_word_ff;
      endcase
      int_res = pcm_sfc_pkg::float_to_int(float_bits,
                                          target_format_ff == pcm_sfc_pkg::FMT_S16);
      if (source_format_ff == target_format_ff) begin
         conv_word = s1_word_ff;
         conv_sat  = 1'b0;
      end else if (target_format_ff inside {pcm_sfc_pkg::FMT_S16, pcm_sfc_pkg::FMT_S32}) begin
         conv_word = int_res[31:0];
         conv_sat  = int_res[32];
      end else begin
         conv_word = float_bits;
         conv_sat  = 1'b0;
      end
   end

   // Next values of the two stages
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_word_in   = s1_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_word_in  = req_tdata;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_word_in  = conv_word;
         rsp_sat_in   = conv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= pcm_sfc_pkg::FMT_FLOAT;
         target_format_ff <= pcm_sfc_pkg::FMT_FLOAT;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         source_format_ff <= source_format_in;
         target_format_ff <= target_format_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_sat_ff;

`include "pcm_sample_format_converter_top_assert.svh"

   // A saturated result is either zero (NaN) or the S32 positive limit
   `PSFC_ASSERT_IMP(a_sat_value, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata == 32'd0 || rsp_tdata == pcm_sfc_pkg::S32_POS_MAX))
   // Saturation only happens for an integer target
   `PSFC_ASSERT_IMP(a_sat_target, clock, reset, rsp_tvalid && rsp_tuser, (target_format_ff == pcm_sfc_pkg::FMT_S16 || target_format_ff == pcm_sfc_pkg::FMT_S32))
   // A held sample is not lost while the result side stalls
   `PSFC_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

/* verif/pcm_sample_format_converter_top_test.sv */
// Self-checking testbench for the PCM sample format converter top level.
`timescale 1ns / 1ps

// Scoreboard: predicts each converted sample and checks results in order.
class sample_scoreboard;
   logic [1:0]  src_fmt;
   logic [1:0]  dst_fmt;
   logic [31:0] want_word[$];
   logic        want_sat[$];
   int          mismatches;
   int          checked;

   function new();
      src_fmt    = pcm_sfc_pkg::FMT_FLOAT;
      dst_fmt    = pcm_sfc_pkg::FMT_FLOAT;
      mismatches = 0;
      checked    = 0;
   endfunction

   // Round n/d * 2^-shift to single precision, nearest even.
   function logic [31:0] ratio_to_float(logic sgn, logic [63:0] n, logic [63:0] d,
                                        int shift);
      logic [127:0] num, q, rem, mant;
      logic         guard, sticky;
      int           p, ex;
      if (n == 0) return 32'd0;
      num = {64'd0, n} << 40;
      q   = num / {64'd0, d};
      rem = num % {64'd0, d};
      p   = 127;
      while (!q[p]) p--;
      mant   = q >> (p - 23);
      guard  = q[p - 24];
      sticky = (rem != 0) || ((q & ((128'd1 << (p - 24)) - 1)) != 0);
      if (guard && (sticky || mant[0])) mant++;
      if (mant[24]) begin
         mant = mant >> 1;
         p++;
      end
      ex = 127 + p - 40 - shift;
      return {sgn, ex[7:0], mant[22:0]};
   endfunction

   // Shift a magnitude by a signed amount, dropping fraction bits.
   function logic [63:0] scale_trunc(logic [63:0] m, int sh);
      if (sh >= 0) return m << sh;
      if (-sh >= 64) return 64'd0;
      return m >> (-sh);
   endfunction

   // Clamp float to [-1,1], scale, truncate; saturation flag in bit 32.
   function logic [32:0] float_to_int(logic [31:0] f, logic to_s16);
      logic [7:0]  e;
      logic [63:0] mant, prod, pm, mag;
      logic [31:0] val;
      logic        guard, sticky;
      int          ex, q, s;
      e = f[30:23];
      if (e == 8'hFF && f[22:0] != 0) return {1'b1, 32'd0};
      if (e >= 8'd127) begin
         if (to_s16) return {1'b0, f[31] ? pcm_sfc_pkg::S16_NEG_MAX : pcm_sfc_pkg::S16_POS_MAX};
         if (f[31]) return {1'b0, pcm_sfc_pkg::S32_NEG_MAX};
         return {1'b1, pcm_sfc_pkg::S32_POS_MAX};
      end
      mant = (e != 0) ? {40'd0, 1'b1, f[22:0]} : {41'd0, f[22:0]};
      ex   = (e != 0) ? int'(e) - 150 : -149;
      if (to_s16) begin
         // product rounds to float before the truncation
         prod = mant * 64'd32767;
         mag  = 0;
         if (prod != 0) begin
            q = 63;
            while (!prod[q]) q--;
            s  = (q > 23) ? q - 23 : 0;
            pm = prod;
            if (s > 0) begin
               pm     = prod >> s;
               guard  = prod[s - 1];
               sticky = (prod & ((64'd1 << (s - 1)) - 1)) != 0;
               if (guard && (sticky || pm[0])) pm++;
               if (pm[24]) begin
                  pm = pm >> 1;
                  s++;
               end
            end
            mag = scale_trunc(pm, s + ex);
         end
      end else begin
         mag = scale_trunc(mant, ex + 31);
      end
      val = f[31] ? (32'd0 - mag[31:0]) : mag[31:0];
      return {1'b0, val};
   endfunction

   // Note an accepted sample and queue its expected conversion.
   function void note_sample(logic [31:0] w);
      logic [31:0] v;
      logic [32:0] r;
      logic [15:0] h;
      logic [31:0] m32;
      if (src_fmt == dst_fmt) begin
         r = {1'b0, w};
      end else begin
         if (src_fmt == pcm_sfc_pkg::FMT_S16) begin
            h = w[15] ? (16'd0 - w[15:0]) : w[15:0];
            v = ratio_to_float(w[15], {48'd0, h}, 64'd32767, 0);
         end else if (src_fmt == pcm_sfc_pkg::FMT_S32) begin
            m32 = w[31] ? (32'd0 - w) : w;
            v   = ratio_to_float(w[31], {32'd0, m32}, 64'd1, 31);
         end else begin
            v = w;
         end
         if (dst_fmt == pcm_sfc_pkg::FMT_S16 || dst_fmt == pcm_sfc_pkg::FMT_S32)
            r = float_to_int(v, dst_fmt == pcm_sfc_pkg::FMT_S16);
         else
            r = {1'b0, v};
      end
      want_word.push_back(r[31:0]);
      want_sat.push_back(r[32]);
   endfunction

   // Compare a result transfer against the oldest expectation.
   function void check_result(logic [31:0] word, logic sat);
      logic [31:0] ew;
      logic        es;
      if (want_word.size() == 0) begin
         $display("%0t: unexpected result word %h sat %b", $time, word, sat);
         mismatches++;
         return;
      end
      ew = want_word.pop_front();
      es = want_sat.pop_front();
      checked++;
      if (word !== ew) begin
         $display("%0t: converted_word expected %h actual %h", $time, ew, word);
         mismatches++;
      end
      if (sat !== es) begin
         $display("%0t: saturated expected %b actual %b", $time, es, sat);
         mismatches++;
      end
   endfunction
endclass

module pcm_sample_format_converter_top_test;

   localparam int         RAND_PER_PHASE = 78;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic        csr_addr;
   logic [1:0]  csr_wdata;

   sample_scoreboard sb;
   bit               calm;
   int               sent;
   logic [31:0]      corner[16];

   pcm_sample_format_converter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Drive result ready with random stalls.
   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
   end

   // Check every result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Send one sample; called and returning at a falling edge.
   task automatic send_sample(logic [31:0] w);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(w);
      sent++;
      @(negedge clock);
   endtask

   // Drain outstanding results, then write both format registers.
   task automatic set_formats(logic [1:0] src, logic [1:0] dst);
      req_tvalid <= 1'b0;
      while (sb.want_word.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= pcm_sfc_pkg::REG_SOURCE;
      csr_wdata <= src;
      @(negedge clock);
      csr_addr  <= pcm_sfc_pkg::REG_TARGET;
      csr_wdata <= dst;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.src_fmt = src;
      sb.dst_fmt = dst;
   endtask

   // Random sample biased toward values near full scale.
   function automatic logic [31:0] random_sample();
      logic [31:0] w;
      logic [7:0]  ex;
      case ($urandom_range(3))
         0: w = $urandom;
         1: begin
            ex = 8'($urandom_range(128, 100));
            w  = {1'($urandom), ex, 23'($urandom)};
         end
         2: w = {16'($urandom), 16'($urandom_range(65535))};
         default: w = $urandom_range(1) ? (32'h7FFF_FFFF - $urandom_range(300))
                                        : (32'h8000_0000 + $urandom_range(300));
      endcase
      return w;
   endfunction

   initial begin
      #2_000_000;
      $display("pcm_sample_format_converter_top_test: errors");
      $finish;
   end

   initial begin
      int ph;
      logic [1:0] s, d;
      sb         = new();
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = pcm_sfc_pkg::REG_SOURCE;
      csr_wdata  = pcm_sfc_pkg::FMT_FLOAT;
      calm       = 1'b0;
      sent       = 0;
      corner = '{32'h0000_0000, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000,
                 32'h0000_8001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h3F7F_FFFF, 32'h8000_0001, 32'hFFFF_8000};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk every source/target pairing, the reset setting first.
      for (ph = 0; ph < 16; ph++) begin
         s = 2'(((ph >> 2) + 2) % 4);
         d = 2'((ph + 2) % 4);
         if (ph != 0) set_formats(s, d);
         calm = (ph >= 6 && ph <= 8);
         foreach (corner[i]) send_sample(corner[i]);
         repeat (RAND_PER_PHASE) send_sample(random_sample());
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (sb.want_word.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Ran %0d samples through all 16 format pairings, %0d results checked.",
               sent, sb.checked);
      if (sb.mismatches == 0 && sb.want_word.size() == 0) begin
         $display("pcm_sample_format_converter_top_test: clean");
      end else begin
         $display("pcm_sample_format_converter_top_test: errors");
      end
      $finish;
   end
endmodule
